@@ rtl/model_transform_matrix_builder_top_defines.svh @@
// ----------------------------------------------------------------------------
// model_transform_matrix_builder_top_defines
// Assertion macros for the model matrix builder.
// ----------------------------------------------------------------------------
`ifndef MODEL_TRANSFORM_MATRIX_BUILDER_TOP_DEFINES_SVH
`define MODEL_TRANSFORM_MATRIX_BUILDER_TOP_DEFINES_SVH
// Check a property at every rising clock edge outside reset.
`define MMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a signal holds while it is stalled.
`define MMB_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy) |=> $stable(sig))) else $error(msg);
`endif

@@ rtl/mmb_pkg.sv @@
// ----------------------------------------------------------------------------
// mmb_pkg
// Types, constants and fixed-point helpers of the model matrix builder.
// ----------------------------------------------------------------------------
package mmb_pkg;
  localparam int FracBits    = 16;
  localparam int CordicSteps = 16;
  // input stage, reduction, CORDIC steps, quadrant map, three product stages
  localparam int PipeDepth   = CordicSteps + 6;
  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic signed [31:0] Q30One = 32'sd1073741824;

  localparam logic signed [31:0] AtanTab [CordicSteps] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379,
    32'sd117300, 32'sd58666, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667,
    32'sd1833, 32'sd917, 32'sd458, 32'sd229, 32'sd115};

  typedef enum logic [0:0] {FUNC_2D = 1'b0, FUNC_3D = 1'b1} func_e;

  // CORDIC lane state
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [1:0]  quad;
    logic               zero;
  } cord_t;

  // Per-item side payload carried along the pipe
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Q multiply with rounding and saturation
  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (FracBits - 1));
    return sat32(p >>> FracBits);
  endfunction

  function automatic logic signed [31:0] q30_to_frac(input logic signed [31:0] v);
    logic signed [32:0] c;
    c = 33'(v);
    if (v < 0) c = '0;
    if (v > Q30One) c = 33'(Q30One);
    c = c + (33'sd1 <<< (29 - FracBits));
    return 32'(c >>> (30 - FracBits));
  endfunction
endpackage

@@ rtl/mmb_sincos.sv @@
// ----------------------------------------------------------------------------
// mmb_sincos
// Pipelined sine/cosine: angle reduction, 16 CORDIC stages, quadrant map.
// ----------------------------------------------------------------------------
module mmb_sincos import mmb_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  cord_t st_q [CordicSteps+1];
  cord_t red_d;
  logic signed [15:0] a_w;
  logic        [14:0] a_red;
  logic        [14:0] r_w;
  logic signed [31:0] c_w, s_w;
  logic signed [31:0] sin_q, cos_q;

  // Reduce into one turn: |angle| < 2 turns so one or two add/compares do it.
  always_comb begin
    a_w = angle_i;
    if (a_w < 0) a_w = a_w + 16'sd23040;
    if (a_w < 0) a_w = a_w + 16'sd23040;
    if (a_w >= 16'sd23040) a_w = a_w - 16'sd23040;
    a_red = a_w[14:0];
    red_d = '0;
    if (a_red >= 15'd17280) begin
      red_d.quad = 2'd3; r_w = a_red - 15'd17280;
    end else if (a_red >= 15'd11520) begin
      red_d.quad = 2'd2; r_w = a_red - 15'd11520;
    end else if (a_red >= 15'd5760) begin
      red_d.quad = 2'd1; r_w = a_red - 15'd5760;
    end else begin
      red_d.quad = 2'd0; r_w = a_red;
    end
    red_d.zero = (r_w == '0);
    red_d.x = CordicGain;
    red_d.y = '0;
    red_d.z = 32'({r_w, 10'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= red_d;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    cord_t nx;
    always_comb begin
      nx = st_q[i];
      if (st_q[i].z >= 0) begin
        nx.x = st_q[i].x - (st_q[i].y >>> i);
        nx.y = st_q[i].y + (st_q[i].x >>> i);
        nx.z = st_q[i].z - AtanTab[i];
      end else begin
        nx.x = st_q[i].x + (st_q[i].y >>> i);
        nx.y = st_q[i].y - (st_q[i].x >>> i);
        nx.z = st_q[i].z + AtanTab[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[i+1] <= nx;
    end
  end

  always_comb begin
    c_w = st_q[CordicSteps].zero ? One : q30_to_frac(st_q[CordicSteps].x);
    s_w = st_q[CordicSteps].zero ? '0  : q30_to_frac(st_q[CordicSteps].y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (st_q[CordicSteps].quad)
        2'd0:    begin sin_q <= s_w;  cos_q <= c_w;  end
        2'd1:    begin sin_q <= c_w;  cos_q <= -s_w; end
        2'd2:    begin sin_q <= -s_w; cos_q <= -c_w; end
        default: begin sin_q <= -c_w; cos_q <= s_w;  end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule

@@ rtl/mmb_matrix.sv @@
// ----------------------------------------------------------------------------
// mmb_matrix
// Three-stage product pipe: rotation terms, rotation entries, scaled columns.
// ----------------------------------------------------------------------------
module mmb_matrix import mmb_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] sx_i, cx_i, sy_i, cy_i, sz_i, cz_i,
  input  side_t              side_i,
  output logic signed [31:0] m_o [3][3],
  output side_t              side_o
);
  logic signed [31:0] sxsy_q, cxsy_q, sx1_q, cx1_q, sy1_q, cy1_q, sz1_q, cz1_q;
  logic signed [31:0] r_q [3][3];
  logic signed [31:0] m_q [3][3];
  side_t s1_q, s2_q, s3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sxsy_q <= fmul(sx_i, sy_i);
      cxsy_q <= fmul(cx_i, sy_i);
      sx1_q <= sx_i; cx1_q <= cx_i; sy1_q <= sy_i;
      cy1_q <= cy_i; sz1_q <= sz_i; cz1_q <= cz_i;
      s1_q <= side_i;
      r_q[0][0] <= fmul(cy1_q, cz1_q);
      r_q[0][1] <= -fmul(cy1_q, sz1_q);
      r_q[0][2] <= sy1_q;
      r_q[1][0] <= fmul(sxsy_q, cz1_q) + fmul(cx1_q, sz1_q);
      r_q[1][1] <= fmul(cx1_q, cz1_q) - fmul(sxsy_q, sz1_q);
      r_q[1][2] <= -fmul(sx1_q, cy1_q);
      r_q[2][0] <= fmul(sx1_q, sz1_q) - fmul(cxsy_q, cz1_q);
      r_q[2][1] <= fmul(cxsy_q, sz1_q) + fmul(sx1_q, cz1_q);
      r_q[2][2] <= fmul(cx1_q, cy1_q);
      s2_q <= s1_q;
      for (int i = 0; i < 3; i++) begin
        m_q[0][i] <= fmul(r_q[i][0], s2_q.sx);
        m_q[1][i] <= fmul(r_q[i][1], s2_q.sy);
        m_q[2][i] <= fmul(r_q[i][2], s2_q.sz);
      end
      s3_q <= s2_q;
    end
  end

  assign m_o = m_q;
  assign side_o = s3_q;
endmodule

@@ rtl/model_transform_matrix_builder_top.sv @@
// ----------------------------------------------------------------------------
// model_transform_matrix_builder_top
// Builds the model matrix T*Rx*Ry*Rz*S and streams it out column by column.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_axis   | in  | one object: translation, angles, scale; tuser = func
//  cfg      | in  | aspect_ratio (Q8.8)
//  m_axis   | out | one matrix column per word, tlast on column 3
//
// An object passes one input stage, 18 sine/cosine stages (reduction, 16
// CORDIC steps, quadrant map) and three product stages before the serializer
// sends its first column. The pipe holds many objects; the four-column
// serializer sets the rate to one object per four output words. Reset clears
// valid bits and sets aspect_ratio to 1.0. A stalled output freezes the whole
// pipe, and s_axis_tready with it, once the last stage holds an object.
module model_transform_matrix_builder_top import mmb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: trans_x[31:0], trans_y[63:32], trans_z[95:64], angle_x[111:96],
  // angle_y[127:112], angle_z[143:128], scale_x[175:144], scale_y[207:176],
  // scale_z[239:208]
  input  logic [239:0] s_axis_tdata,
  // tuser: func[0]
  input  logic         s_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: column_index[1:0], elem_row0..3 at [33:2],[65:34],[97:66],[129:98],
  // zeros above
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  `include "model_transform_matrix_builder_top_defines.svh"

  logic [15:0] aspect_q;
  logic [PipeDepth-1:0] vld_q;
  logic en;
  logic in_fire;
  logic last_beat;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  side_t side_in_q, side_d;
  side_t side_pipe_q [CordicSteps+2];
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [31:0] m_w [3][3];
  side_t side_out;
  logic signed [31:0] col_q [4][4];
  logic [1:0] col_idx_q;
  logic busy_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) aspect_q <= 16'd256;
    else if (cfg_valid) aspect_q <= cfg_data;
  end

  // Hold the whole pipe while the last stage has an object and the serializer
  // cannot take it this cycle.
  assign last_beat = busy_q && m_axis_tready && (col_idx_q == 2'd3);
  assign en = !busy_q || last_beat || !vld_q[PipeDepth-1];
  assign s_axis_tready = en;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    side_d.tx = s_axis_tdata[31:0];
    side_d.ty = s_axis_tdata[63:32];
    side_d.sx = s_axis_tdata[175:144];
    if (s_axis_tuser == FUNC_3D) begin
      side_d.tz = s_axis_tdata[95:64];
      side_d.sy = s_axis_tdata[207:176];
      side_d.sz = s_axis_tdata[239:208];
    end else begin
      // 2D: drop z translation, unit z scale, aspect-corrected y scale
      side_d.tz = '0;
      side_d.sz = One;
      side_d.sy = sat32(((64'(signed'(s_axis_tdata[207:176])) *
                          64'(signed'({1'b0, aspect_q}))) + 64'sd128) >>> 8);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_in_q <= side_d;
      ax_q <= (s_axis_tuser == FUNC_3D) ? s_axis_tdata[111:96] : '0;
      ay_q <= (s_axis_tuser == FUNC_3D) ? s_axis_tdata[127:112] : '0;
      az_q <= s_axis_tdata[143:128];
      side_pipe_q[0] <= side_in_q;
      for (int i = 1; i < CordicSteps + 2; i++) side_pipe_q[i] <= side_pipe_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[PipeDepth-2:0], in_fire};
  end

  mmb_sincos u_sc_x (.clk_i, .en_i(en), .angle_i(ax_q), .sin_o(sx), .cos_o(cx));
  mmb_sincos u_sc_y (.clk_i, .en_i(en), .angle_i(ay_q), .sin_o(sy), .cos_o(cy));
  mmb_sincos u_sc_z (.clk_i, .en_i(en), .angle_i(az_q), .sin_o(sz), .cos_o(cz));

  mmb_matrix u_mat (
    .clk_i, .en_i(en),
    .sx_i(sx), .cx_i(cx), .sy_i(sy), .cy_i(cy), .sz_i(sz), .cz_i(cz),
    .side_i(side_pipe_q[CordicSteps+1]),
    .m_o(m_w), .side_o(side_out)
  );

  // Output serializer: load a finished matrix, advance one column per word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_idx_q <= '0;
    end else if (en && vld_q[PipeDepth-1]) begin
      busy_q <= 1'b1;
      col_idx_q <= '0;
    end else if (busy_q && m_axis_tready) begin
      col_idx_q <= col_idx_q + 2'd1;
      if (col_idx_q == 2'd3) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[PipeDepth-1]) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) col_q[j][i] <= m_w[j][i];
        col_q[j][3] <= '0;
      end
      col_q[3][0] <= side_out.tx;
      col_q[3][1] <= side_out.ty;
      col_q[3][2] <= side_out.tz;
      col_q[3][3] <= One;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast = (col_idx_q == 2'd3);
  assign m_axis_tdata = {6'b0, col_q[col_idx_q][3], col_q[col_idx_q][2],
                         col_q[col_idx_q][1], col_q[col_idx_q][0], col_idx_q};

  `MMB_ASSERT(a_last_idx, m_axis_tvalid && m_axis_tlast |-> col_idx_q == 2'd3, "tlast off column 3")
  `MMB_ASSERT(a_load_free, en && vld_q[PipeDepth-1] |-> !busy_q || last_beat, "serializer overrun")
  `MMB_ASSERT_HOLD(a_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "output word changed while stalled")
endmodule
